>>> sv/cdbcr_pkg.sv
// ---------------------------------------------------------------------------
// cdbcr_pkg
// Types and constants shared by the CD block command register logic.
// ---------------------------------------------------------------------------
package cdbcr_pkg;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  reg_select;
        logic [15:0] write_data;
    } in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [15:0] irq_flags;
    } out_t;

    // access kinds
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    // register selects
    localparam logic [2:0] SEL_FLAGS = 3'd0;
    localparam logic [2:0] SEL_MASK  = 3'd1;
    localparam logic [2:0] SEL_CW1   = 3'd2;
    localparam logic [2:0] SEL_CW2   = 3'd3;
    localparam logic [2:0] SEL_CW3   = 3'd4;
    localparam logic [2:0] SEL_CW4   = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_DRIVE_STATUS = 3'd0;
    localparam logic [2:0] CFG_PLAY_OPTIONS = 3'd1;
    localparam logic [2:0] CFG_REPEAT_COUNT = 3'd2;
    localparam logic [2:0] CFG_CTRL_ADDR    = 3'd3;
    localparam logic [2:0] CFG_TRACK        = 3'd4;
    localparam logic [2:0] CFG_INDEX        = 3'd5;

    // command codes (high byte of command word 1)
    localparam logic [7:0] OP_STATUS     = 8'h00;
    localparam logic [7:0] OP_HW_INFO    = 8'h01;
    localparam logic [7:0] OP_TOC        = 8'h02;
    localparam logic [7:0] OP_SESSION    = 8'h03;
    localparam logic [7:0] OP_INIT       = 8'h04;
    localparam logic [7:0] OP_END_XFER   = 8'h06;
    localparam logic [7:0] OP_RESET_SEL  = 8'h48;
    localparam logic [7:0] OP_SECTOR_LEN = 8'h60;
    localparam logic [7:0] OP_COPY_ERR   = 8'h67;
    localparam logic [7:0] OP_ABORT      = 8'h75;
    localparam logic [7:0] OP_MPEG_INIT  = 8'h93;

    // interrupt flag bits
    localparam logic [15:0] FLAG_CMOK = 16'h0001;
    localparam logic [15:0] FLAG_DRDY = 16'h0002;
    localparam logic [15:0] FLAG_ESEL = 16'h0040;
    localparam logic [15:0] FLAG_EFLS = 16'h0200;
    localparam logic [15:0] FLAG_MPED = 16'h0800;
    localparam logic [15:0] FLAG_MPCM = 16'h1000;
    localparam logic [15:0] FLAG_MPST = 16'h2000;
    localparam logic [15:0] FLAG_WR_FORCE = 16'h0402;

    localparam logic [15:0] HW_INFO_W2 = 16'h0201;
    localparam logic [15:0] HW_INFO_W4 = 16'h0400;
    localparam logic [15:0] MPEG_W2_MATCH = 16'h0001;
    localparam logic [31:0] XFER_TOC   = 32'h0000_00CC;
    localparam logic [31:0] XFER_ABORT = 32'hFFFF_FFFF;
    localparam logic [23:0] FRAME_START = 24'd150;

    localparam logic [15:0] FLAGS_RESET = 16'h07D3;
    localparam logic [15:0] MASK_RESET  = 16'h07FF;
    localparam logic [15:0] CW1_RESET   = 16'h0043;
    localparam logic [15:0] CW2_RESET   = 16'h4442;
    localparam logic [15:0] CW3_RESET   = 16'h4C4F;
    localparam logic [15:0] CW4_RESET   = 16'h434B;

endpackage

>>> sv/cd_block_command_registers_top.sv
// ---------------------------------------------------------------------------
// cd_block_command_registers_top
// Host register block of a CD drive controller: flags, mask, command words
// and the command decoder that fills the response words.
// ---------------------------------------------------------------------------
// Path: an accepted request goes into the input register; its decoded result
// goes into the result register (input register, then result register), where
// it waits until it is taken.
// Throughput: one request per cycle unless the output stalls; the command
// decode sits between the input register and the result register.
// Reset (aresetn low, synchronous): registers return to their power-on values,
// both stages empty.
module cd_block_command_registers_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cdbcr_pkg::in_t     s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cdbcr_pkg::out_t    m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import cdbcr_pkg::*;

    logic [7:0]  drive_status_reg;
    logic [3:0]  play_options_reg;
    logic [3:0]  repeat_count_reg;
    logic [7:0]  ctrl_addr_reg;
    logic [7:0]  track_reg;
    logic [7:0]  index_reg;

    logic [15:0] irq_flag_reg, irq_flag_next;
    logic [15:0] irq_mask_reg, irq_mask_next;
    logic [15:0] cw_reg  [4];
    logic [15:0] cw_next [4];
    logic [23:0] frame_addr_reg, frame_addr_next;
    logic [31:0] xfer_count_reg, xfer_count_next;

    logic        in_valid_reg;
    in_t         in_data_reg;
    logic        out_valid_reg;
    out_t        out_data_reg, out_data_next;
    logic        advance;

    logic [15:0] hi;
    logic [15:0] rpt_w1, rpt_w2, rpt_w3, rpt_w4;
    logic [15:0] raise;
    logic [15:0] rd;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // status report words
    assign hi     = {drive_status_reg, 8'h00};
    assign rpt_w1 = {drive_status_reg, play_options_reg, repeat_count_reg};
    assign rpt_w2 = {ctrl_addr_reg, track_reg};
    assign rpt_w3 = {index_reg, frame_addr_reg[23:16]};
    assign rpt_w4 = frame_addr_reg[15:0];

    always_comb begin
        irq_flag_next   = irq_flag_reg;
        irq_mask_next   = irq_mask_reg;
        cw_next         = cw_reg;
        frame_addr_next = frame_addr_reg;
        xfer_count_next = xfer_count_reg;
        raise           = '0;
        rd              = '0;

        if (in_data_reg.cmd == ACC_WRITE) begin
            case (in_data_reg.reg_select)
                SEL_FLAGS: irq_flag_next = (irq_flag_reg & in_data_reg.write_data)
                                           | FLAG_WR_FORCE;
                SEL_MASK:  irq_mask_next = in_data_reg.write_data;
                SEL_CW1:   cw_next[0] = in_data_reg.write_data;
                SEL_CW2:   cw_next[1] = in_data_reg.write_data;
                SEL_CW3:   cw_next[2] = in_data_reg.write_data;
                SEL_CW4: begin
                    cw_next[3] = in_data_reg.write_data;
                    case (cw_reg[0][15:8])
                        OP_STATUS: begin
                            cw_next = '{rpt_w1, rpt_w2, rpt_w3, rpt_w4};
                            raise   = FLAG_CMOK;
                        end
                        OP_HW_INFO: begin
                            cw_next = '{hi, HW_INFO_W2, 16'h0000, HW_INFO_W4};
                            raise   = FLAG_CMOK;
                        end
                        OP_TOC: begin
                            xfer_count_next = XFER_TOC;
                            cw_next = '{hi, XFER_TOC[15:0], 16'h0000, 16'h0000};
                            raise   = FLAG_CMOK | FLAG_DRDY;
                        end
                        OP_SESSION: begin
                            cw_next = '{hi, 16'h0000, 16'h0000, 16'h0000};
                            raise   = FLAG_CMOK | FLAG_DRDY;
                        end
                        OP_INIT: begin
                            // frame address restarts; options nibble left out
                            frame_addr_next = FRAME_START;
                            cw_next = '{{drive_status_reg, 4'h0, repeat_count_reg},
                                        rpt_w2,
                                        {index_reg, FRAME_START[23:16]},
                                        FRAME_START[15:0]};
                            raise   = FLAG_CMOK;
                        end
                        OP_END_XFER: begin
                            cw_next = '{{drive_status_reg, xfer_count_reg[23:16]},
                                        xfer_count_reg[15:0], 16'h0000, 16'h0000};
                            raise   = FLAG_CMOK | FLAG_DRDY;
                        end
                        OP_RESET_SEL, OP_SECTOR_LEN: begin
                            cw_next = '{rpt_w1, rpt_w2, rpt_w3, rpt_w4};
                            raise   = FLAG_CMOK | FLAG_ESEL;
                        end
                        OP_COPY_ERR: begin
                            cw_next = '{hi, 16'h0000, 16'h0000, 16'h0000};
                            raise   = FLAG_CMOK;
                        end
                        OP_ABORT: begin
                            xfer_count_next = XFER_ABORT;
                            cw_next = '{rpt_w1, rpt_w2, rpt_w3, rpt_w4};
                            raise   = FLAG_CMOK | FLAG_ESEL | FLAG_EFLS;
                        end
                        OP_MPEG_INIT: begin
                            cw_next = '{hi, 16'h0000, 16'h0000, 16'h0000};
                            raise   = FLAG_CMOK | FLAG_MPED | FLAG_MPST;
                            if (cw_reg[1] == MPEG_W2_MATCH) begin
                                raise = raise | FLAG_MPCM;
                            end
                        end
                        default: raise = '0;
                    endcase
                    // drop command-done, then raise the completion flags
                    irq_flag_next = (irq_flag_reg & ~FLAG_CMOK) | raise;
                end
                default: irq_flag_next = irq_flag_reg;
            endcase
        end else begin
            case (in_data_reg.reg_select)
                SEL_FLAGS: rd = irq_flag_reg;
                SEL_MASK:  rd = irq_mask_reg;
                SEL_CW1:   rd = cw_reg[0];
                SEL_CW2:   rd = cw_reg[1];
                SEL_CW3:   rd = cw_reg[2];
                SEL_CW4:   rd = cw_reg[3];
                default:   rd = '0;
            endcase
        end

        out_data_next.read_data = rd;
        out_data_next.irq_flags = irq_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            drive_status_reg <= 8'h21;
            play_options_reg <= 4'h0;
            repeat_count_reg <= 4'h0;
            ctrl_addr_reg    <= 8'h41;
            track_reg        <= 8'h01;
            index_reg        <= 8'h01;
            irq_flag_reg     <= FLAGS_RESET;
            irq_mask_reg     <= MASK_RESET;
            cw_reg           <= '{CW1_RESET, CW2_RESET, CW3_RESET, CW4_RESET};
            frame_addr_reg   <= FRAME_START;
            xfer_count_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                irq_flag_reg   <= irq_flag_next;
                irq_mask_reg   <= irq_mask_next;
                cw_reg         <= cw_next;
                frame_addr_reg <= frame_addr_next;
                xfer_count_reg <= xfer_count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_DRIVE_STATUS: drive_status_reg <= cfg_data;
                    CFG_PLAY_OPTIONS: play_options_reg <= cfg_data[3:0];
                    CFG_REPEAT_COUNT: repeat_count_reg <= cfg_data[3:0];
                    CFG_CTRL_ADDR:    ctrl_addr_reg    <= cfg_data;
                    CFG_TRACK:        track_reg        <= cfg_data;
                    CFG_INDEX:        index_reg        <= cfg_data;
                    default:          track_reg        <= track_reg;
                endcase
            end
        end
    end

    // payload registers: hold until the stage advances
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // a result waiting at the output always shows the live flag register
    a_flags_track: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.irq_flags == irq_flag_reg))
        else $error("result flags differ from flag register");

    // a flag write always leaves bits 1 and 10 set
    a_flag_force: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.cmd == ACC_WRITE && in_data_reg.reg_select == SEL_FLAGS)
        |=> (irq_flag_reg[1] && irq_flag_reg[10]))
        else $error("flag write lost forced bits");

    // input stage stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without output back-pressure");

    // a write request always returns zero read data
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.cmd == ACC_WRITE) |=> (out_data_reg.read_data == 16'h0000))
        else $error("write returned non-zero read data");

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the CD block host register file. Drives host
// register reads and writes, including command words 1 to 4 to fire drive
// commands, and predicts every response from a shadow copy of the flags,
// mask, command words, frame address and transfer count. Runs a short table
// of directed requests, then randomised command sequences under several
// settings of the drive status registers, with random stalls on both sides.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdbcr_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int PLAN_ROWS   = 30;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 210;
    localparam int MAX_REPORTS = 30;

    // selects and indexes that map to nothing
    localparam logic [2:0] SEL_SPARE_LO = 3'd6;
    localparam logic [2:0] SEL_SPARE_HI = 3'd7;
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam logic [7:0] OP_UNKNOWN   = 8'hFF;

    typedef struct packed {
        logic pinned;
        in_t  req;
        out_t want;
    } plan_row_t;

    typedef struct packed {
        logic [2:0] idx;
        logic [7:0] val;
    } setting_t;

    logic  aclk;
    logic  aresetn   = 1'b0;
    logic  s_valid   = 1'b0;
    logic  s_ready;
    in_t   s_data    = '0;
    logic  m_valid;
    logic  m_ready   = 1'b0;
    out_t  m_data;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    cd_block_command_registers_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the register file
    logic [15:0] flags_sh    = FLAGS_RESET;
    logic [15:0] mask_sh     = MASK_RESET;
    logic [15:0] cmdw_sh [4] = '{CW1_RESET, CW2_RESET, CW3_RESET, CW4_RESET};
    logic [23:0] frame_sh    = FRAME_START;
    logic [31:0] xfer_sh     = '0;
    logic [7:0]  status_sh   = 8'h21;
    logic [3:0]  options_sh  = 4'h0;
    logic [3:0]  repeat_sh   = 4'h0;
    logic [7:0]  ctrl_addr_sh = 8'h41;
    logic [7:0]  track_sh    = 8'h01;
    logic [7:0]  index_sh    = 8'h01;

    out_t        pending_responses [$];
    setting_t    settings_q [$];
    plan_row_t   plan_table [PLAN_ROWS];
    logic [7:0]  known_ops [11] = '{OP_STATUS, OP_HW_INFO, OP_TOC, OP_SESSION, OP_INIT,
                                    OP_END_XFER, OP_RESET_SEL, OP_SECTOR_LEN, OP_COPY_ERR,
                                    OP_ABORT, OP_MPEG_INIT};

    int unsigned mismatch_count = 0;
    int unsigned requests_sent  = 0;
    int unsigned commands_run   = 0;
    int unsigned quiet_cycles   = 0;
    bit          no_idle        = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t MISMATCH %s: got %04h, want %04h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void load_words(input logic [15:0] w1, input logic [15:0] w2,
                                       input logic [15:0] w3, input logic [15:0] w4);
        cmdw_sh[0] = w1;
        cmdw_sh[1] = w2;
        cmdw_sh[2] = w3;
        cmdw_sh[3] = w4;
    endfunction

    function automatic void load_status_report(input bit with_options);
        load_words({status_sh, with_options ? options_sh : 4'h0, repeat_sh},
                   {ctrl_addr_sh, track_sh},
                   {index_sh, frame_sh[23:16]},
                   frame_sh[15:0]);
    endfunction

    // Apply one host request to the shadow and return the response it gives.
    task automatic host_access(input in_t req, output out_t rsp);
        logic [15:0] hi;
        logic [15:0] raise;
        rsp.read_data = '0;
        if (req.cmd == ACC_WRITE) begin
            case (req.reg_select)
                SEL_FLAGS: flags_sh = (flags_sh & req.write_data) | FLAG_WR_FORCE;
                SEL_MASK:  mask_sh = req.write_data;
                SEL_CW1, SEL_CW2, SEL_CW3:
                    cmdw_sh[2'(req.reg_select - SEL_CW1)] = req.write_data;
                SEL_CW4: begin
                    cmdw_sh[3] = req.write_data;
                    commands_run++;
                    hi    = {status_sh, 8'h00};
                    raise = '0;
                    // command done drops first, whatever the code
                    flags_sh = flags_sh & ~FLAG_CMOK;
                    case (cmdw_sh[0][15:8])
                        OP_STATUS: begin
                            load_status_report(1'b1);
                            raise = FLAG_CMOK;
                        end
                        OP_HW_INFO: begin
                            load_words(hi, HW_INFO_W2, '0, HW_INFO_W4);
                            raise = FLAG_CMOK;
                        end
                        OP_TOC: begin
                            xfer_sh = XFER_TOC;
                            load_words(hi, XFER_TOC[15:0], '0, '0);
                            raise = FLAG_CMOK | FLAG_DRDY;
                        end
                        OP_SESSION: begin
                            load_words(hi, '0, '0, '0);
                            raise = FLAG_CMOK | FLAG_DRDY;
                        end
                        OP_INIT: begin
                            frame_sh = FRAME_START;
                            load_status_report(1'b0);
                            raise = FLAG_CMOK;
                        end
                        OP_END_XFER: begin
                            load_words(hi | {8'h00, xfer_sh[23:16]}, xfer_sh[15:0], '0, '0);
                            raise = FLAG_CMOK | FLAG_DRDY;
                        end
                        OP_RESET_SEL, OP_SECTOR_LEN: begin
                            load_status_report(1'b1);
                            raise = FLAG_CMOK | FLAG_ESEL;
                        end
                        OP_COPY_ERR: begin
                            load_words(hi, '0, '0, '0);
                            raise = FLAG_CMOK;
                        end
                        OP_ABORT: begin
                            xfer_sh = XFER_ABORT;
                            load_status_report(1'b1);
                            raise = FLAG_CMOK | FLAG_ESEL | FLAG_EFLS;
                        end
                        OP_MPEG_INIT: begin
                            raise = FLAG_CMOK | FLAG_MPED | FLAG_MPST;
                            if (cmdw_sh[1] == MPEG_W2_MATCH)
                                raise = raise | FLAG_MPCM;
                            load_words(hi, '0, '0, '0);
                        end
                        default: ;
                    endcase
                    flags_sh = flags_sh | raise;
                end
                default: ;
            endcase
        end else begin
            case (req.reg_select)
                SEL_FLAGS: rsp.read_data = flags_sh;
                SEL_MASK:  rsp.read_data = mask_sh;
                SEL_CW1, SEL_CW2, SEL_CW3, SEL_CW4:
                    rsp.read_data = cmdw_sh[2'(req.reg_select - SEL_CW1)];
                default: rsp.read_data = '0;
            endcase
        end
        rsp.irq_flags = flags_sh;
    endtask

    // Present one request, hold it until taken, then log what it should return.
    task automatic send_request(input in_t req, input logic pinned, input out_t want);
        out_t rsp;
        if (!no_idle && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 13);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        host_access(req, rsp);
        pending_responses.push_back(pinned ? want : rsp);
        requests_sent++;
    endtask

    task automatic access(input logic cmd, input logic [2:0] sel, input logic [15:0] data);
        in_t req;
        req.cmd        = cmd;
        req.reg_select = sel;
        req.write_data = data;
        send_request(req, 1'b0, '0);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_settings;
        foreach (settings_q[k]) begin
            cfg_valid <= 1'b1;
            cfg_index <= settings_q[k].idx;
            cfg_data  <= settings_q[k].val;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (settings_q[k].idx)
                CFG_DRIVE_STATUS: status_sh    = settings_q[k].val;
                CFG_PLAY_OPTIONS: options_sh   = settings_q[k].val[3:0];
                CFG_REPEAT_COUNT: repeat_sh    = settings_q[k].val[3:0];
                CFG_CTRL_ADDR:    ctrl_addr_sh = settings_q[k].val;
                CFG_TRACK:        track_sh     = settings_q[k].val;
                CFG_INDEX:        index_sh     = settings_q[k].val;
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_q.delete();
    endtask

    // Mostly host-style command sequences, the rest single random accesses.
    task automatic random_traffic(input int unsigned n);
        int unsigned stop_at;
        logic [7:0]  op;
        int          reads;
        stop_at = requests_sent + n;
        while (requests_sent < stop_at) begin
            if ($urandom_range(99) < 70) begin
                // acknowledge some interrupts first
                if ($urandom_range(99) < 25)
                    access(ACC_WRITE, SEL_FLAGS, 16'($urandom));
                if ($urandom_range(99) < 85)
                    op = known_ops[$urandom_range(10)];
                else
                    op = 8'($urandom);
                access(ACC_WRITE, SEL_CW1, {op, 8'($urandom)});
                if ($urandom_range(99) < 30)
                    access(ACC_WRITE, SEL_CW2,
                           $urandom_range(1) ? MPEG_W2_MATCH : 16'($urandom));
                if ($urandom_range(99) < 15)
                    access(ACC_WRITE, SEL_CW3, 16'($urandom));
                access(ACC_WRITE, SEL_CW4, 16'($urandom));
                reads = $urandom_range(4);
                repeat (reads) access(ACC_READ, 3'($urandom_range(5)), 16'($urandom));
            end else begin
                access(1'($urandom), 3'($urandom), 16'($urandom));
            end
        end
    endtask

    // response checker
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response with no request outstanding",
                                m_data.read_data, '0);
            end else begin
                want = pending_responses.pop_front();
                if (m_data.read_data !== want.read_data)
                    report_mismatch("read_data", m_data.read_data, want.read_data);
                if (m_data.irq_flags !== want.irq_flags)
                    report_mismatch("irq_flags", m_data.irq_flags, want.irq_flags);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= no_idle || ($urandom_range(99) >= 13);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("watchdog: %0d cycles without a handshake, %0d responses owed",
                         QUIET_LIMIT, pending_responses.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        plan_table = '{
            '{1'b1, '{ACC_READ,  SEL_FLAGS,    16'h0000}, '{FLAGS_RESET, FLAGS_RESET}},
            '{1'b1, '{ACC_READ,  SEL_MASK,     16'hFFFF}, '{MASK_RESET,  FLAGS_RESET}},
            '{1'b1, '{ACC_READ,  SEL_SPARE_HI, 16'hFFFF}, '{16'h0000,    FLAGS_RESET}},
            '{1'b1, '{ACC_WRITE, SEL_SPARE_LO, 16'hFFFF}, '{16'h0000,    FLAGS_RESET}},
            '{1'b1, '{ACC_WRITE, SEL_FLAGS,    16'h0000}, '{16'h0000,    FLAG_WR_FORCE}},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_STATUS,     8'h00}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'hFFFF}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_HW_INFO,    8'hFF}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'h0000}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_TOC,        8'h5A}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'hA5A5}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_END_XFER,   8'hA5}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'h5A5A}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_SESSION,    8'h01}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'hFFFF}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_INIT,       8'h80}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'h0000}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_RESET_SEL,  8'h7F}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'h1234}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_SECTOR_LEN, 8'h33}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'hEDCB}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_COPY_ERR,   8'hCC}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'h8000}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_ABORT,      8'h0F}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'h0001}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_MPEG_INIT,  8'hF0}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW2, MPEG_W2_MATCH}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'h7FFF}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW1, {OP_UNKNOWN,    8'hFF}}, '0},
            '{1'b0, '{ACC_WRITE, SEL_CW4, 16'hFFFF}, '0}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan_table[r])
            send_request(plan_table[r].req, plan_table[r].pinned, plan_table[r].want);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: for (int i = 0; i < 6; i++) settings_q.push_back('{3'(i), 8'h00});
                1: begin
                    for (int i = 0; i < 6; i++) settings_q.push_back('{3'(i), 8'hFF});
                    settings_q.push_back('{CFG_SPARE_HI, 8'hFF});
                end
                default: begin
                    for (int i = 0; i < 6; i++)
                        settings_q.push_back('{3'(i), 8'($urandom)});
                    settings_q.push_back('{CFG_SPARE_LO, 8'($urandom)});
                end
            endcase
            write_settings();
            // one phase runs flat out on both sides
            no_idle = (p == 2);
            random_traffic(PHASE_ITEMS);
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("run covered %0d host requests, %0d of them firing drive commands,",
                 requests_sent, commands_run);
        $display("over reset settings plus %0d further settings; %0d mismatches",
                 PHASES, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
sv/cdbcr_pkg.sv
sv/cd_block_command_registers_top.sv
tb/tb.sv
